// ----- rtl/core/rbp_pkg.sv -----
// Shared types and codes of the receive buffer pool.
// Used by rbp_ctrl, rbp_datapath and receive_buffer_pool_top; depends on nothing.
package rbp_pkg;

  // Command codes of the input beat.
  localparam logic [2:0] CMD_GET     = 3'd0;
  localparam logic [2:0] CMD_SAVE    = 3'd1;
  localparam logic [2:0] CMD_RETURN  = 3'd2;
  localparam logic [2:0] CMD_CLN_TAG = 3'd3;
  localparam logic [2:0] CMD_CLN_LNK = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_CONN  = 2'd0;
  localparam logic [1:0] REG_BLKS  = 2'd1;
  localparam logic [1:0] REG_BSIZE = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  slot;
    logic [15:0] data_handle;
    logic [31:0] conn_tag;
    logic [15:0] link_tag;
  } rbp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  out_slot;
    logic [16:0] buffer_size;
    logic [15:0] out_handle;
    logic [6:0]  freed_count;
  } rbp_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic load;
    logic dispatch;
    logic q_rd;
    logic t_rd_q;
    logic t_rd_slot;
    logic wr;
    logic scan_rd;
    logic scan_chk;
    logic res_load;
  } rbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       rebuild;
    logic       clr_last;
    logic [2:0] op;
    logic       empty;
    logic       slot_bad;
    logic       scan_last;
    logic       out_full;
  } rbp_sts_t;

endpackage

// ----- rtl/core/rbp_ctrl.sv -----
// Sequencing state machine of the receive buffer pool.
// Depends on rbp_pkg; drives rbp_datapath through command and status structs.
module rbp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rbp_pkg::rbp_sts_t sts,
  output rbp_pkg::rbp_cmd_t cmd,
  output logic              in_stall
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_GET_Q, S_WR, S_SCAN_RD, S_SCAN_CHK, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // The next state and the commands for the datapath.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE) || sts.rebuild;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !sts.rebuild) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        case (sts.op)
          rbp_pkg::CMD_GET: begin
            if (sts.empty) begin
              state_nxt = S_DONE;
            end else begin
              cmd.q_rd  = 1'b1;
              state_nxt = S_GET_Q;
            end
          end
          rbp_pkg::CMD_SAVE, rbp_pkg::CMD_RETURN: begin
            if (sts.slot_bad) begin
              state_nxt = S_DONE;
            end else begin
              cmd.t_rd_slot = 1'b1;
              state_nxt     = S_WR;
            end
          end
          rbp_pkg::CMD_CLN_TAG, rbp_pkg::CMD_CLN_LNK: state_nxt = S_SCAN_RD;
          default: state_nxt = S_DONE;
        endcase
      end
      S_GET_Q: begin
        cmd.t_rd_q = 1'b1;
        state_nxt  = S_WR;
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_DONE;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        state_nxt    = sts.scan_last ? S_DONE : S_SCAN_RD;
      end
      S_DONE: begin
        if (!sts.out_full) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    // A configuration write rebuilds the pool from scratch.
    if (sts.rebuild) begin
      cmd       = '0;
      state_nxt = S_CLEAR;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/rbp_datapath.sv -----
// Datapath of the receive buffer pool: configuration, free list, slot memories, result.
// Depends on rbp_pkg; sequenced by rbp_ctrl.
module rbp_datapath #(
  parameter int SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  rbp_pkg::rbp_in_t  in_data,
  input  logic              out_stall,
  output logic              out_valid,
  output rbp_pkg::rbp_res_t out_data,
  input  rbp_pkg::rbp_cmd_t cmd,
  output rbp_pkg::rbp_sts_t sts
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // Configuration and pool size.
  logic [7:0]  conn_r, blks_r;
  logic [15:0] bsize_r;
  logic [CW-1:0] pool_r, pool_nxt;
  logic [16:0] prod;
  logic [17:0] pool_raw;
  logic [16:0] bsum, buf_size;

  // Free list, item and scan state.
  logic [AW-1:0] head_r, clr_idx_r, scan_idx_r, sel_r;
  logic [CW-1:0] cnt_r, freed_r;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  rbp_pkg::rbp_in_t item_r;
  logic [1:0]  stat_r;
  logic [5:0]  oslot_r;
  logic [15:0] ohandle_r;
  logic        out_valid_r;
  rbp_pkg::rbp_res_t res_r;

  // Memories: free queue, {used, tag} per slot, handle per slot.
  logic [AW-1:0] qmem [SLOTS];
  logic [32:0]   tmem [SLOTS];
  logic [15:0]   hmem [SLOTS];
  logic [AW-1:0] q_rd_r;
  logic [32:0]   t_rd_r;
  logic [15:0]   h_rd_r;

  logic          q_we, t_we, h_we, t_re;
  logic [AW-1:0] q_wa, t_wa, t_ra;
  logic [AW-1:0] q_wd;
  logic [32:0]   t_wd;
  logic          rel, used_bit, hit, rebuild, slot_bad;

  assign rebuild = cfg_we && (cfg_index == rbp_pkg::REG_CONN || cfg_index == rbp_pkg::REG_BLKS
                              || cfg_index == rbp_pkg::REG_BSIZE);

  // Pool size min(2 + conn * (blocks + 1), SLOTS) and buffer size.
  always_comb begin
    prod     = 17'(conn_r) * 17'({1'b0, blks_r} + 9'd1);
    pool_raw = 18'(prod) + 18'd2;
    pool_nxt = (pool_raw > 18'(SLOTS)) ? CW'(SLOTS) : CW'(pool_raw);
    bsum     = 17'd128 + 17'(bsize_r);
    buf_size = (bsum < 17'd2048) ? 17'd2048 : bsum;
  end

  // Tail of the circular free queue.
  always_comb begin
    tail_sum = (CW + 1)'(head_r) + (CW + 1)'(cnt_r);
    tail     = (tail_sum >= (CW + 1)'(SLOTS)) ? AW'(tail_sum - (CW + 1)'(SLOTS))
                                                : AW'(tail_sum);
  end

  assign slot_bad = (32'(item_r.slot) >= 32'(pool_r));
  assign used_bit = t_rd_r[32];
  assign hit      = (item_r.cmd == rbp_pkg::CMD_CLN_TAG) ? (t_rd_r[31:0] == item_r.conn_tag)
                                                         : (t_rd_r[15:0] == item_r.link_tag);

  // Memory port control.
  always_comb begin
    q_we = 1'b0; q_wa = tail; q_wd = sel_r;
    t_we = 1'b0; t_wa = sel_r; t_wd = '0;
    h_we = 1'b0;
    t_re = cmd.t_rd_q || cmd.t_rd_slot || cmd.scan_rd;
    t_ra = cmd.t_rd_q ? q_rd_r : (cmd.scan_rd ? scan_idx_r : AW'(item_r.slot));
    rel  = 1'b0;
    if (cmd.clr) begin
      q_we = 1'b1; q_wa = clr_idx_r; q_wd = clr_idx_r;
      t_we = 1'b1; t_wa = clr_idx_r;
    end else if (cmd.wr) begin
      case (item_r.cmd)
        rbp_pkg::CMD_GET: begin
          t_we = 1'b1; t_wd = {1'b1, t_rd_r[31:0]};
        end
        rbp_pkg::CMD_SAVE: begin
          t_we = 1'b1; t_wd = {used_bit, item_r.conn_tag}; h_we = 1'b1;
        end
        rbp_pkg::CMD_RETURN: begin
          rel = used_bit; t_we = used_bit; q_we = used_bit;
        end
        default: ;
      endcase
    end else if (cmd.scan_chk) begin
      rel  = used_bit && (t_rd_r[31:0] != 32'd0) && hit;
      t_we = rel; t_wa = scan_idx_r;
      q_we = rel; q_wd = scan_idx_r;
    end
  end

  // Memory arrays with registered reads.
  always_ff @(posedge clk) begin
    if (q_we) qmem[q_wa] <= q_wd;
    if (t_we) tmem[t_wa] <= t_wd;
    if (h_we) hmem[sel_r] <= item_r.data_handle;
    if (cmd.q_rd) q_rd_r <= qmem[head_r];
    if (t_re) t_rd_r <= tmem[t_ra];
    if (cmd.t_rd_slot) h_rd_r <= hmem[AW'(item_r.slot)];
  end

  // Configuration registers and registered pool size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r  <= 8'd1;
      blks_r  <= 8'd7;
      bsize_r <= 16'd2048;
    end else if (cfg_we) begin
      case (cfg_index)
        rbp_pkg::REG_CONN:  conn_r  <= cfg_data[7:0];
        rbp_pkg::REG_BLKS:  blks_r  <= cfg_data[7:0];
        rbp_pkg::REG_BSIZE: bsize_r <= cfg_data;
        default: ;
      endcase
    end
    pool_r <= pool_nxt;
  end

  // Free list pointers and clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n || rebuild) begin
      head_r    <= '0;
      cnt_r     <= '0;
      clr_idx_r <= '0;
    end else begin
      if (cmd.clr) begin
        clr_idx_r <= clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(SLOTS - 1)) cnt_r <= pool_r;
      end
      if (cmd.wr && item_r.cmd == rbp_pkg::CMD_GET) begin
        head_r <= (head_r == AW'(SLOTS - 1)) ? '0 : head_r + AW'(1);
        cnt_r  <= cnt_r - CW'(1);
      end
      if (rel) cnt_r <= cnt_r + CW'(1);
    end
  end

  // Item register and result accumulation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r     <= in_data;
      stat_r     <= rbp_pkg::ST_OK;
      oslot_r    <= '0;
      ohandle_r  <= '0;
      freed_r    <= '0;
      scan_idx_r <= '0;
    end
    if (cmd.dispatch) begin
      sel_r <= AW'(item_r.slot);
      if (item_r.cmd == rbp_pkg::CMD_GET && cnt_r == '0) stat_r <= rbp_pkg::ST_EMPTY;
      if ((item_r.cmd == rbp_pkg::CMD_SAVE || item_r.cmd == rbp_pkg::CMD_RETURN) && slot_bad)
        stat_r <= rbp_pkg::ST_BAD;
    end
    if (cmd.t_rd_q) sel_r <= q_rd_r;
    if (cmd.wr) begin
      if (item_r.cmd == rbp_pkg::CMD_GET) oslot_r <= 6'(sel_r);
      if (item_r.cmd == rbp_pkg::CMD_RETURN) begin
        if (used_bit) ohandle_r <= h_rd_r;
        else stat_r <= rbp_pkg::ST_BAD;
      end
    end
    if (cmd.scan_chk) begin
      scan_idx_r <= scan_idx_r + AW'(1);
      if (used_bit && t_rd_r[31:0] == 32'd0) stat_r <= rbp_pkg::ST_BAD;
      if (rel) freed_r <= freed_r + CW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.res_load) begin
      res_r.status      <= stat_r;
      res_r.out_slot    <= oslot_r;
      res_r.buffer_size <= buf_size;
      res_r.out_handle  <= ohandle_r;
      res_r.freed_count <= 7'(freed_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_comb begin
    sts.rebuild   = rebuild;
    sts.clr_last  = (clr_idx_r == AW'(SLOTS - 1));
    sts.op        = item_r.cmd;
    sts.empty     = (cnt_r == '0);
    sts.slot_bad  = slot_bad;
    sts.scan_last = (32'(scan_idx_r) == 32'(pool_r) - 32'd1);
    sts.out_full  = out_valid_r && out_stall;
  end

endmodule

// ----- rtl/core/receive_buffer_pool_top.sv -----
// Top level of the receive buffer pool: controller and datapath.
// Depends on rbp_pkg, rbp_ctrl and rbp_datapath.
//
//   Port group  Direction  Handshake          Payload
//   in_         in         in_valid/in_stall  rbp_pkg::rbp_in_t
//   out_        out        out_valid/out_stall rbp_pkg::rbp_res_t
//   cfg_        in         cfg_we             cfg_index, cfg_data
//
// One item is worked on at a time. A get passes dispatch, queue read, write and
// done; save and return skip the queue read. A cleanup reads and checks each pool
// slot of the shared tag memory in turn. Unknown or rejected items go from dispatch
// to done. After reset and every configuration write a clearing pass over all SLOTS
// entries refills the free queue and clears the tags; no beat is accepted
// meanwhile. A result waits in the output register while out_stall is high.
module receive_buffer_pool_top #(
  parameter int SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  rbp_pkg::rbp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rbp_pkg::rbp_res_t out_data
);

  rbp_pkg::rbp_cmd_t cmd;
  rbp_pkg::rbp_sts_t sts;

  rbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  rbp_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // A configuration write starts a clearing pass, so the next beat is refused.
  a_rebuild_stall: assert property (@(posedge clk) disable iff (!rst_n)
    sts.rebuild |=> in_stall)
    else $error("beat offered acceptance right after a pool rebuild");

  // Only one item is in flight.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat accepted while an item is in work");

  // Loading a result always raises the output valid.
  a_res_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid)
    else $error("result loaded without out_valid");

endmodule
